>>> design/cbag_pkg.sv
package cbag_pkg;

  localparam int DEF_SCREEN_MAX = 4096;
  localparam int DEF_ADDR_BITS  = 48;

  localparam int PIXEL_BYTES = 4;
  localparam int PIXEL_SHIFT = $clog2(PIXEL_BYTES);

  localparam int SCREEN_DIM_W = 13;
  localparam int DEST_PITCH_W = 14;
  localparam int DEST_INDEX_W = 25;
  localparam int OUT_ADDR_W   = 48;
  localparam int CFG_ADDR_W   = 4;
  localparam int CFG_DATA_W   = 32;

  localparam logic [SCREEN_DIM_W-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
  localparam logic [SCREEN_DIM_W-1:0] SCREEN_HEIGHT_RESET = 13'd768;
  localparam logic [DEST_PITCH_W-1:0] DEST_PITCH_RESET    = 14'd1024;

  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DEST_PITCH    = 2'd2;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef enum logic [1:0] {
    ST_STARTED  = 2'd0,
    ST_REJECTED = 2'd1,
    ST_TRANSFER = 2'd2,
    ST_IDLE     = 2'd3
  } status_t;

  typedef struct packed {
    logic [SCREEN_DIM_W-1:0] screen_width;
    logic [SCREEN_DIM_W-1:0] screen_height;
    logic [DEST_PITCH_W-1:0] dest_pitch_words;
  } cfg_t;

endpackage

>>> design/cbag_regs.sv
module cbag_regs
  import cbag_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width     <= SCREEN_WIDTH_RESET;
      cfg.screen_height    <= SCREEN_HEIGHT_RESET;
      cfg.dest_pitch_words <= DEST_PITCH_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_SCREEN_WIDTH:  cfg.screen_width     <= pwdata[SCREEN_DIM_W-1:0];
        REG_SCREEN_HEIGHT: cfg.screen_height    <= pwdata[SCREEN_DIM_W-1:0];
        REG_DEST_PITCH:    cfg.dest_pitch_words <= pwdata[DEST_PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SCREEN_WIDTH:  prdata = CFG_DATA_W'(cfg.screen_width);
      REG_SCREEN_HEIGHT: prdata = CFG_DATA_W'(cfg.screen_height);
      REG_DEST_PITCH:    prdata = CFG_DATA_W'(cfg.dest_pitch_words);
      default:           prdata = '0;
    endcase
  end

endmodule

>>> design/clipped_rect_blit_address_gen.sv
// Channel   Direction  Handshake                      Contents
// s_axis    in         s_axis_tvalid / s_axis_tready  start or step request
// m_axis    out        m_axis_tvalid / m_axis_tready  status and pixel transfer
// apb       in         psel, penable, pwrite, pready  screen size, dest pitch
//
// Every request yields one result, through the input register and then the result
// register, and a new request can be taken every cycle while the result does not stall.
// The input register and the result register are the two stages; clipping,
// the origin multiply and the address adds sit between them.
// Reset clears the blit state, the stage valids and restores the register defaults.
// A stalled result holds the result register while one more request waits in
// the input register.
module clipped_rect_blit_address_gen
  import cbag_pkg::*;
#(
  parameter int SCREEN_MAX = DEF_SCREEN_MAX,
  parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // source_base[47:0], source_pitch[63:48], rect_width[79:64],
  // rect_height[95:80], origin_x[111:96], origin_y[127:112]
  input  logic [127:0]          s_axis_tdata,
  // command[0]
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // source_address[47:0], dest_index[72:48], zero[79:73]
  output logic [79:0]           m_axis_tdata,
  // status[1:0]
  output logic [1:0]            m_axis_tuser,
  output logic                  m_axis_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int DIM_W = $clog2(SCREEN_MAX + 1);
  localparam int CNT_W = $clog2(SCREEN_MAX);

  cfg_t cfg;

  cbag_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic         in_valid;
  logic         in_cmd;
  logic [127:0] in_data;
  logic         advance;

  logic                    busy;
  logic [DIM_W-1:0]        clipped_width;
  logic [DIM_W-1:0]        clipped_height;
  logic [CNT_W-1:0]        row_count;
  logic [CNT_W-1:0]        column_count;
  logic [ADDR_BITS-1:0]    source_row_address;
  logic [15:0]             latched_pitch;
  logic [DEST_INDEX_W-1:0] dest_row_index;

  logic                    out_valid;
  status_t                 out_status;
  logic [ADDR_BITS-1:0]    out_addr;
  logic [DEST_INDEX_W-1:0] out_index;
  logic                    out_last;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd  <= s_axis_tuser[0];
      in_data <= s_axis_tdata;
    end
  end

  logic [47:0] f_base;
  logic [15:0] f_pitch;
  logic [15:0] f_width;
  logic [15:0] f_height;
  logic [15:0] f_x;
  logic [15:0] f_y;

  assign f_base   = in_data[47:0];
  assign f_pitch  = in_data[63:48];
  assign f_width  = in_data[79:64];
  assign f_height = in_data[95:80];
  assign f_x      = in_data[111:96];
  assign f_y      = in_data[127:112];

  logic [SCREEN_DIM_W:0]            sw_ext;
  logic [SCREEN_DIM_W:0]            sh_ext;
  logic [DIM_W-1:0]                 sw;
  logic [DIM_W-1:0]                 sh;
  logic [DIM_W-1:0]                 avail_w;
  logic [DIM_W-1:0]                 avail_h;
  logic [DIM_W-1:0]                 clip_w;
  logic [DIM_W-1:0]                 clip_h;
  logic                             start_ok;
  logic [DIM_W+DEST_PITCH_W-1:0]    origin_prod;
  logic [DEST_INDEX_W-1:0]          origin_index;
  logic [DIM_W:0]                   col_plus;
  logic [DIM_W:0]                   row_plus;
  logic                             end_row;
  logic                             last_px;
  logic [ADDR_BITS-1:0]             px_addr;
  logic [DEST_INDEX_W-1:0]          px_index;

  always_comb begin
    sw_ext = {1'b0, cfg.screen_width};
    sh_ext = {1'b0, cfg.screen_height};
    sw = (sw_ext > (SCREEN_DIM_W + 1)'(SCREEN_MAX)) ? DIM_W'(SCREEN_MAX) : DIM_W'(sw_ext);
    sh = (sh_ext > (SCREEN_DIM_W + 1)'(SCREEN_MAX)) ? DIM_W'(SCREEN_MAX) : DIM_W'(sh_ext);
    avail_w = sw - f_x[DIM_W-1:0];
    avail_h = sh - f_y[DIM_W-1:0];
    clip_w = (f_width > 16'(avail_w)) ? avail_w : f_width[DIM_W-1:0];
    clip_h = (f_height > 16'(avail_h)) ? avail_h : f_height[DIM_W-1:0];
    start_ok = (f_base != '0) && (f_x < 16'(sw)) && (f_y < 16'(sh)) &&
               (clip_w != '0) && (clip_h != '0);
    origin_prod = (DIM_W + DEST_PITCH_W)'(f_y[DIM_W-1:0]) *
                  (DIM_W + DEST_PITCH_W)'(cfg.dest_pitch_words);
    origin_index = DEST_INDEX_W'(origin_prod) + DEST_INDEX_W'(f_x[DIM_W-1:0]);

    col_plus = (DIM_W + 1)'(column_count) + (DIM_W + 1)'(1);
    row_plus = (DIM_W + 1)'(row_count) + (DIM_W + 1)'(1);
    end_row  = col_plus >= (DIM_W + 1)'(clipped_width);
    last_px  = end_row && (row_plus >= (DIM_W + 1)'(clipped_height));
    px_addr  = source_row_address + (ADDR_BITS'(column_count) << PIXEL_SHIFT);
    px_index = dest_row_index + DEST_INDEX_W'(column_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy               <= 1'b0;
      clipped_width      <= '0;
      clipped_height     <= '0;
      row_count          <= '0;
      column_count       <= '0;
      source_row_address <= '0;
      latched_pitch      <= '0;
      dest_row_index     <= '0;
    end else if (advance) begin
      if (in_cmd == CMD_START) begin
        busy <= start_ok;
        if (start_ok) begin
          clipped_width      <= clip_w;
          clipped_height     <= clip_h;
          row_count          <= '0;
          column_count       <= '0;
          source_row_address <= ADDR_BITS'(f_base);
          latched_pitch      <= f_pitch;
          dest_row_index     <= origin_index;
        end
      end else if (busy) begin
        if (end_row) begin
          column_count       <= '0;
          row_count          <= CNT_W'(row_plus);
          source_row_address <= source_row_address + ADDR_BITS'(latched_pitch);
          dest_row_index     <= dest_row_index + DEST_INDEX_W'(cfg.dest_pitch_words);
          if (last_px) begin
            busy <= 1'b0;
          end
        end else begin
          column_count <= CNT_W'(col_plus);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_addr  <= '0;
      out_index <= '0;
      out_last  <= 1'b0;
      if (in_cmd == CMD_START) begin
        out_status <= start_ok ? ST_STARTED : ST_REJECTED;
      end else if (!busy) begin
        out_status <= ST_IDLE;
      end else begin
        out_status <= ST_TRANSFER;
        out_addr   <= px_addr;
        out_index  <= px_index;
        out_last   <= last_px;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {7'd0, out_index, OUT_ADDR_W'(out_addr)};

  a_busy_dims: assert property (@(posedge clk) disable iff (rst)
    busy |-> (clipped_width != '0) && (clipped_height != '0))
    else $error("busy with an empty rectangle");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> ((DIM_W + 1)'(column_count) < (DIM_W + 1)'(clipped_width)))
    else $error("column count beyond clipped width");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> ((DIM_W + 1)'(row_count) < (DIM_W + 1)'(clipped_height)))
    else $error("row count beyond clipped height");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (advance && in_cmd == CMD_STEP && busy && last_px) |=> !busy)
    else $error("blit still busy after its final transfer");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_TRANSFER) |->
      (out_addr == '0) && (out_index == '0) && !out_last)
    else $error("nonzero transfer fields outside a transfer");

endmodule

>>> bench/tb_clipped_rect_blit_address_gen.sv
module tb_clipped_rect_blit_address_gen
  import cbag_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 50;

  typedef struct packed {
    logic [15:0] origin_y;
    logic [15:0] origin_x;
    logic [15:0] rect_height;
    logic [15:0] rect_width;
    logic [15:0] source_pitch;
    logic [47:0] source_base;
  } blit_req_t;

  typedef struct {
    status_t     status;
    logic [47:0] src;
    logic [24:0] dst;
    logic        last;
  } transfer_t;

  class transfer_tracker;
    logic [12:0] scr_w;
    logic [12:0] scr_h;
    logic [13:0] row_step_words;
    bit          busy;
    int unsigned clip_w;
    int unsigned clip_h;
    int unsigned row_n;
    int unsigned col_n;
    logic [47:0] row_src;
    logic [15:0] row_step_bytes;
    logic [24:0] row_dst;
    transfer_t   due_transfers[$];
    int          errors;

    function new();
      scr_w = SCREEN_WIDTH_RESET;
      scr_h = SCREEN_HEIGHT_RESET;
      row_step_words = DEST_PITCH_RESET;
      busy = 1'b0;
      clip_w = 0;
      clip_h = 0;
      row_n = 0;
      col_n = 0;
      row_src = '0;
      row_step_bytes = '0;
      row_dst = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_SCREEN_WIDTH: scr_w = value[12:0];
        REG_SCREEN_HEIGHT: scr_h = value[12:0];
        REG_DEST_PITCH: row_step_words = value[13:0];
        default: ;
      endcase
    endfunction

    function int unsigned screen_cols();
      return (scr_w > DEF_SCREEN_MAX) ? DEF_SCREEN_MAX : scr_w;
    endfunction

    function int unsigned screen_rows();
      return (scr_h > DEF_SCREEN_MAX) ? DEF_SCREEN_MAX : scr_h;
    endfunction

    function int unsigned transfers_left();
      if (!busy) return 0;
      return (clip_h - row_n - 1) * clip_w + (clip_w - col_n);
    endfunction

    function int pending();
      return due_transfers.size();
    endfunction

    function void note_request(logic cmd, blit_req_t r);
      transfer_t   e;
      int unsigned cols;
      int unsigned rows;
      int unsigned w;
      int unsigned h;
      logic [63:0] origin_word;
      bit          end_row;
      e.status = ST_IDLE;
      e.src = '0;
      e.dst = '0;
      e.last = 1'b0;
      if (cmd == CMD_START) begin
        cols = screen_cols();
        rows = screen_rows();
        w = r.rect_width;
        h = r.rect_height;
        busy = 1'b0;
        e.status = ST_REJECTED;
        if (r.source_base != 0 && r.origin_x < cols && r.origin_y < rows) begin
          if (w > cols - r.origin_x) w = cols - r.origin_x;
          if (h > rows - r.origin_y) h = rows - r.origin_y;
          if (w != 0 && h != 0) begin
            busy = 1'b1;
            clip_w = w;
            clip_h = h;
            row_n = 0;
            col_n = 0;
            row_src = r.source_base;
            row_step_bytes = r.source_pitch;
            origin_word = 64'(r.origin_y) * 64'(row_step_words) + 64'(r.origin_x);
            row_dst = origin_word[24:0];
            e.status = ST_STARTED;
          end
        end
      end else if (busy) begin
        e.status = ST_TRANSFER;
        e.src = row_src + 48'(col_n) * 48'(PIXEL_BYTES);
        e.dst = row_dst + 25'(col_n);
        end_row = (col_n + 1 >= clip_w);
        e.last = end_row && (row_n + 1 >= clip_h);
        if (end_row) begin
          col_n = 0;
          row_n++;
          row_src = row_src + 48'(row_step_bytes);
          row_dst = row_dst + 25'(row_step_words);
          if (e.last) busy = 1'b0;
        end else begin
          col_n++;
        end
      end
      due_transfers.push_back(e);
    endfunction

    function void check_transfer(logic [1:0] st, logic [47:0] sa, logic [24:0] di,
                                 logic last, logic [6:0] pad);
      transfer_t e;
      if (due_transfers.size() == 0) begin
        $error("unrequested result: status %0d", st);
        errors++;
        return;
      end
      e = due_transfers.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (sa !== e.src) begin
        $error("source_address: expected %h, got %h", e.src, sa);
        errors++;
      end
      if (di !== e.dst) begin
        $error("dest_index: expected %0d, got %0d", e.dst, di);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_transfer: expected %0d, got %0d", e.last, last);
        errors++;
      end
      if (pad !== '0) begin
        $error("zero padding: expected 0, got %h", pad);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [127:0]          s_axis_tdata;
  logic [0:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [79:0]           m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  transfer_tracker tracker = new();
  bit              steady;
  logic            hold_wanted;
  int              hold_left;
  int              sent;
  int              cycle_count;

  clipped_rect_blit_address_gen uut (.*);

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_clipped_rect_blit_address_gen: done, errors");
      $finish;
    end
  end

  // Result side: check each accepted result, then choose the next ready.
  initial begin
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        tracker.check_transfer(m_axis_tuser, m_axis_tdata[47:0], m_axis_tdata[72:48],
                               m_axis_tlast, m_axis_tdata[79:73]);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_wanted) begin
        hold_wanted <= 1'b0;
        hold_left = 299;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 23);
      end
    end
  end

  function automatic blit_req_t any_fields();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic blit_req_t blit(logic [47:0] base, logic [15:0] pitch,
                                     logic [15:0] w, logic [15:0] h,
                                     logic [15:0] x, logic [15:0] y);
    return '{origin_y: y, origin_x: x, rect_height: h, rect_width: w,
             source_pitch: pitch, source_base: base};
  endfunction

  function automatic logic [15:0] pick_coord(int unsigned n);
    int unsigned span;
    span = (n - 1 < 7) ? n - 1 : 7;
    if ($urandom_range(1)) return 16'(n - 1 - $urandom_range(span, 0));
    return 16'($urandom_range(n - 1, 0));
  endfunction

  function automatic logic [15:0] pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 16'($urandom_range(6, 1));
    if (r < 80) return 16'd0;
    if (r < 90) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic send(logic cmd, blit_req_t r);
    while (!steady && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= r;
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_request(cmd, r);
    sent++;
  endtask

  task automatic step(int n);
    repeat (n) send(CMD_STEP, any_fields());
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= CFG_ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_reg(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_random(int n);
    int          first;
    int unsigned pick;
    int unsigned cols;
    int unsigned rows;
    int unsigned left;
    int unsigned take;
    blit_req_t   r;
    first = sent;
    while (sent - first < n) begin
      pick = $urandom_range(99);
      cols = tracker.screen_cols();
      rows = tracker.screen_rows();
      r = any_fields();
      if (pick < 65) begin
        if (r.source_base == 0) r.source_base = 48'd1;
        if (cols > 0) r.origin_x = pick_coord(cols);
        if (rows > 0) r.origin_y = pick_coord(rows);
        r.rect_width = pick_size();
        r.rect_height = pick_size();
        send(CMD_START, r);
        left = tracker.transfers_left();
        take = (left > 40) ? $urandom_range(40, 1) : left;
        if (take > 1 && $urandom_range(9) == 0) begin
          take = $urandom_range(take - 1, 1);
        end else if ($urandom_range(3) == 0) begin
          take += $urandom_range(2, 1);
        end
        step(take);
      end else if (pick < 80) begin
        send(CMD_START, r);
      end else if (pick < 92) begin
        case ($urandom_range(2))
          0: r.source_base = '0;
          1: r.origin_x = 16'(cols + $urandom_range(3));
          default: r.origin_y = 16'(rows + $urandom_range(3));
        endcase
        send(CMD_START, r);
      end else begin
        step(1);
      end
    end
  endtask

  task automatic configure(logic [12:0] w, logic [12:0] h, logic [13:0] pitch);
    write_reg(REG_SCREEN_WIDTH, 32'(w));
    write_reg(REG_SCREEN_HEIGHT, 32'(h));
    write_reg(REG_DEST_PITCH, 32'(pitch));
  endtask

  initial begin
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= CMD_START;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    hold_wanted <= 1'b0;
    steady = 1'b0;
    sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    step(1);
    send(CMD_START, blit(48'd0, 16'd4, 16'd2, 16'd2, 16'd0, 16'd0));
    send(CMD_START, blit(48'd64, 16'd4, 16'd2, 16'd2, 16'd1024, 16'd0));
    send(CMD_START, blit(48'd64, 16'd4, 16'd2, 16'd2, 16'd0, 16'd768));
    send(CMD_START, blit(48'd64, 16'd4, 16'd0, 16'd2, 16'd0, 16'd0));
    send(CMD_START, blit(48'd64, 16'd4, 16'd2, 16'd0, 16'd0, 16'd0));
    send(CMD_START, blit(48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF));
    // Clipped to the bottom right corner, with the source address wrapping.
    send(CMD_START, blit(48'hFFFF_FFFF_FFF8, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'd1022, 16'd766));
    step(5);
    // A new start replaces a blit in progress.
    send(CMD_START, blit(48'd1, 16'd4, 16'd3, 16'd2, 16'd0, 16'd0));
    step(2);
    send(CMD_START, blit(48'h8000_0000_0000, 16'd0, 16'd1, 16'd1, 16'd5, 16'd5));
    step(1);
    // The destination pitch changes between rows of one blit.
    send(CMD_START, blit(48'h1000, 16'd256, 16'd1, 16'd3, 16'd10, 16'd10));
    step(1);
    drain();
    write_reg(REG_DEST_PITCH, 32'd8192);
    step(2);
    drain();

    configure(13'd16, 13'd16, 14'd16);
    run_random(PHASE_ITEMS);
    drain();
    configure(13'd4096, 13'd4096, 14'd8192);
    steady = 1'b1;
    hold_wanted <= 1'b1;
    run_random(PHASE_ITEMS);
    drain();
    steady = 1'b0;
    configure(13'd8191, 13'd8191, 14'd16383);
    run_random(PHASE_ITEMS);
    drain();
    configure(13'd0, 13'd0, 14'd3);
    run_random(PHASE_ITEMS / 2);
    drain();
    configure(13'd1, 13'd4096, 14'd0);
    run_random(PHASE_ITEMS);
    drain();
    configure(13'd4096, 13'd1, 14'd1);
    run_random(PHASE_ITEMS);
    drain();
    configure(13'($urandom_range(300, 2)), 13'($urandom_range(300, 2)),
              14'($urandom_range(16383)));
    run_random(PHASE_ITEMS);
    drain();
    configure(SCREEN_WIDTH_RESET, SCREEN_HEIGHT_RESET, DEST_PITCH_RESET);
    run_random(PHASE_ITEMS);

    s_axis_tvalid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("tb_clipped_rect_blit_address_gen: done, clean");
    end else begin
      $display("tb_clipped_rect_blit_address_gen: done, errors");
    end
    $finish;
  end

endmodule
